@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the top-level RTL file to check its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define BTCC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define BTCC_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ hw/rtl/btcc_pkg.sv @@
// Types and constants for the bilinear table with cubic correction.
package btcc_pkg;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_EVAL  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    SEL_A = 2'd0,
    SEL_B = 2'd1,
    SEL_C = 2'd2,
    SEL_D = 2'd3
  } coef_sel_e;

  typedef enum logic [1:0] {
    CFG_STEPS = 2'd0,
    CFG_RECIP = 2'd1,
    CFG_SCALE = 2'd2
  } cfg_idx_e;

  // widest azimuth index over the supported bin counts
  localparam int unsigned AZ_IDX_W  = 10;
  localparam int unsigned IN_DEPTH  = 4;
  localparam int unsigned OUT_DEPTH = 32;
  localparam int unsigned PEND_W    = $clog2(OUT_DEPTH + 1);

  // queued item: table write or classified query
  typedef struct packed {
    op_e                   op;
    logic                  beam;
    logic [4:0]            w_orbit;
    logic [5:0]            w_az;
    coef_sel_e             sel;
    logic [31:0]           data;
    logic [AZ_IDX_W-1:0]   a1;
    logic [AZ_IDX_W-1:0]   a2;
    logic [15:0]           ca2;
    logic [29:0]           f;
    logic signed [39:0]    x;
  } entry_t;

  // one Horner step: acc*x/2^16 + c_c, then the remaining coefficients move up
  typedef struct packed {
    logic signed [63:0] acc;
    logic signed [47:0] c_c;
    logic signed [47:0] c_b;
    logic signed [47:0] c_a;
    logic [39:0]        x_mag;
    logic               x_neg;
    logic               sat;
  } horner_pkt_t;

endpackage

@@ hw/rtl/btcc_fifo.sv @@
// Small register FIFO used for the item queue and the result queue.
module btcc_fifo #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic [W-1:0] data_o,
  output logic         valid_o
);
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_q [DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

@@ hw/rtl/btcc_front.sv @@
// Front end: classifies items, drops bad writes, works out bins and x.
module btcc_front #(
  parameter int unsigned AZIMUTH_BINS = 64,
  parameter int unsigned BEAMS        = 2,
  parameter int unsigned ORBIT_BINS   = 32
) (
  input  logic               operation_i,
  input  logic               beam_i,
  input  logic [4:0]         orbit_bin_i,
  input  logic [5:0]         azimuth_bin_i,
  input  logic [1:0]         coefficient_select_i,
  input  logic signed [31:0] coefficient_value_i,
  input  logic [15:0]        azimuth_turn_i,
  input  logic [15:0]        orbit_fraction_i,
  input  logic signed [23:0] frequency_offset_i,
  input  logic [13:0]        steps_i,
  input  logic [23:0]        scale_i,
  output logic               keep_o,
  output btcc_pkg::entry_t   entry_o
);
  import btcc_pkg::*;

  localparam int unsigned AW = $clog2(AZIMUTH_BINS);
  localparam int unsigned PW = 16 + AW;

  logic [PW-1:0]      p;
  logic [AW-1:0]      p_hi, a1, a2;
  logic signed [24:0] scale_s;
  logic signed [47:0] x_prod;
  logic               wr_ok;

  assign p       = PW'(azimuth_turn_i) * PW'(AZIMUTH_BINS);
  assign p_hi    = p[PW-1:16];
  assign a1      = (32'(p_hi) >= AZIMUTH_BINS) ? AW'(AZIMUTH_BINS - 1) : p_hi;
  assign a2      = (32'(a1) == AZIMUTH_BINS - 1) ? '0 : a1 + 1'b1;
  assign scale_s = {1'b0, scale_i};
  assign x_prod  = frequency_offset_i * scale_s;

  assign wr_ok = (32'(beam_i) < BEAMS) && (32'(orbit_bin_i) < ORBIT_BINS)
              && (32'(azimuth_bin_i) < AZIMUTH_BINS);

  always_comb begin
    entry_o         = '0;
    entry_o.op      = op_e'(operation_i);
    entry_o.w_orbit = orbit_bin_i;
    entry_o.w_az    = azimuth_bin_i;
    entry_o.sel     = coef_sel_e'(coefficient_select_i);
    entry_o.data    = coefficient_value_i;
    entry_o.a1      = AZ_IDX_W'(a1);
    entry_o.a2      = AZ_IDX_W'(a2);
    entry_o.ca2     = p[15:0];
    entry_o.f       = 30'(orbit_fraction_i) * 30'(steps_i);
    entry_o.x       = x_prod[47:8];
    if (entry_o.op == OP_EVAL) begin
      entry_o.beam = (32'(beam_i) >= BEAMS) ? 1'(BEAMS - 1) : beam_i;
    end else begin
      entry_o.beam = beam_i;
    end
    keep_o = (entry_o.op == OP_EVAL) || wr_ok;
  end

endmodule

@@ hw/rtl/btcc_interp.sv @@
// Back end part one: coefficient memories and bilinear blend of four planes.
module btcc_interp #(
  parameter int unsigned AZIMUTH_BINS = 64,
  parameter int unsigned ORBIT_BINS   = 32,
  parameter int unsigned BEAMS        = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [13:0]           steps_i,
  input  logic [23:0]           recip_i,
  input  logic                  pop_i,
  input  btcc_pkg::entry_t      head_i,
  output logic                  valid_o,
  output btcc_pkg::horner_pkt_t pkt_o
);
  import btcc_pkg::*;

  localparam int unsigned AW        = $clog2(AZIMUTH_BINS);
  localparam int unsigned TW        = $clog2(ORBIT_BINS);
  localparam int unsigned BW        = (BEAMS > 1) ? $clog2(BEAMS) : 1;
  localparam int unsigned MAW       = BW + TW + AW;
  localparam int unsigned MEM_DEPTH = 1 << MAW;
  localparam logic [5:0]  LAST_T6   = 6'(ORBIT_BINS - 1);

  // issue stage
  logic [5:0]     t1_raw;
  logic           last_bin;
  logic [TW-1:0]  t1, t2;
  logic [AW-1:0]  a1, a2;
  logic [BW-1:0]  beam;
  logic [29:0]    span_lo, span_hi;
  logic [53:0]    w_lo, w_hi;
  logic [29:0]    ct1_d, ct2_d;
  logic [MAW-1:0] rd_addr [2][2];
  logic [MAW-1:0] wr_addr;
  logic           wr_en;
  logic           eval_go;

  assign t1_raw   = head_i.f[29:24];
  assign last_bin = (32'(t1_raw) >= ORBIT_BINS - 1);
  assign t1       = last_bin ? TW'(ORBIT_BINS - 1) : TW'(t1_raw);
  assign t2       = last_bin ? '0 : TW'(t1_raw) + 1'b1;
  assign a1       = AW'(head_i.a1);
  assign a2       = AW'(head_i.a2);
  assign beam     = BW'(head_i.beam);
  assign span_lo  = head_i.f - {LAST_T6, 24'b0};
  assign span_hi  = {steps_i, 16'b0} - head_i.f;
  assign w_lo     = 54'(span_lo) * 54'(recip_i);
  assign w_hi     = 54'(span_hi) * 54'(recip_i);
  assign ct2_d    = last_bin ? w_lo[53:24] : 30'(head_i.f[23:8]);
  assign ct1_d    = last_bin ? w_hi[53:24] : 30'(17'h10000 - {1'b0, head_i.f[23:8]});
  assign eval_go  = pop_i && (head_i.op == OP_EVAL);
  assign wr_en    = pop_i && (head_i.op == OP_WRITE);
  assign wr_addr  = {BW'(head_i.beam), TW'(head_i.w_orbit), AW'(head_i.w_az)};

  assign rd_addr[0][0] = {beam, t1, a1};
  assign rd_addr[0][1] = {beam, t1, a2};
  assign rd_addr[1][0] = {beam, t2, a1};
  assign rd_addr[1][1] = {beam, t2, a2};

  // one copy per orbit row, so each memory serves two reads
  logic signed [31:0] rd_data [4][2][2];

  for (genvar gp = 0; gp < 4; gp++) begin : g_plane
    for (genvar gr = 0; gr < 2; gr++) begin : g_row
      logic [31:0] mem_q [MEM_DEPTH];
      logic [31:0] rd0_q, rd1_q;
      always_ff @(posedge clk_i) begin
        if (wr_en && (head_i.sel == coef_sel_e'(gp))) begin
          mem_q[wr_addr] <= head_i.data;
        end
        rd0_q <= mem_q[rd_addr[gr][0]];
        rd1_q <= mem_q[rd_addr[gr][1]];
      end
      assign rd_data[gp][gr][0] = rd0_q;
      assign rd_data[gp][gr][1] = rd1_q;
    end
  end

  // pipeline registers
  logic               v1_q, v2_q, v3_q, v4_q;
  logic [15:0]        ca2_1_q;
  logic [29:0]        ct1_1_q, ct2_1_q, ct1_2_q, ct2_2_q;
  logic signed [39:0] x1_q, x2_q, x3_q, x4_q;
  logic signed [31:0] blend_q [4][2];
  logic signed [62:0] prod_q  [4][2];
  logic signed [47:0] coef_q  [4];

  logic signed [17:0] ca1_s, ca2_s;
  logic signed [50:0] az_sum  [4][2];
  logic signed [30:0] ct1_s, ct2_s;
  logic signed [63:0] orb_sum [4];

  assign ca2_s = {2'b0, ca2_1_q};
  assign ca1_s = 18'sh10000 - ca2_s;
  assign ct1_s = {1'b0, ct1_2_q};
  assign ct2_s = {1'b0, ct2_2_q};

  always_comb begin
    for (int p = 0; p < 4; p++) begin
      for (int r = 0; r < 2; r++) begin
        az_sum[p][r] = ca1_s * rd_data[p][r][0] + ca2_s * rd_data[p][r][1];
      end
      orb_sum[p] = prod_q[p][0] + prod_q[p][1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= eval_go;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ca2_1_q <= head_i.ca2;
    ct1_1_q <= ct1_d;
    ct2_1_q <= ct2_d;
    x1_q    <= head_i.x;
    ct1_2_q <= ct1_1_q;
    ct2_2_q <= ct2_1_q;
    x2_q    <= x1_q;
    x3_q    <= x2_q;
    x4_q    <= x3_q;
    for (int p = 0; p < 4; p++) begin
      for (int r = 0; r < 2; r++) begin
        blend_q[p][r] <= az_sum[p][r][47:16];
      end
      prod_q[p][0] <= ct1_s * blend_q[p][0];
      prod_q[p][1] <= ct2_s * blend_q[p][1];
      coef_q[p]    <= orb_sum[p][63:16];
    end
  end

  assign valid_o = v4_q;

  always_comb begin
    pkt_o       = '0;
    pkt_o.acc   = {{16{coef_q[SEL_D][47]}}, coef_q[SEL_D]};
    pkt_o.c_c   = coef_q[SEL_C];
    pkt_o.c_b   = coef_q[SEL_B];
    pkt_o.c_a   = coef_q[SEL_A];
    pkt_o.x_neg = x4_q[39];
    pkt_o.x_mag = x4_q[39] ? (~x4_q + 40'd1) : x4_q;
    pkt_o.sat   = 1'b0;
  end

endmodule

@@ hw/rtl/btcc_horner.sv @@
// Back end part two: one pipelined Horner step, acc = acc*x/2^16 + c.
module btcc_horner (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  btcc_pkg::horner_pkt_t pkt_i,
  output logic                  valid_o,
  output btcc_pkg::horner_pkt_t pkt_o
);
  import btcc_pkg::*;

  logic          va_q, vb_q, vc_q, vo_q;
  horner_pkt_t   pa_q, pb_q, pc_q, po_q;
  logic [63:0]   mag_q;
  logic          neg_a_q, neg_b_q, neg_c_q;
  logic [63:0]   pp00_q, pp10_q;
  logic [39:0]   pp01_q, pp11_q;
  logic [103:0]  m_q;

  logic [103:0]  m_sum;
  logic          cap, rnd;
  logic [62:0]   r;
  logic [63:0]   r64, c64;
  horner_pkt_t   po_d;

  assign m_sum = {40'b0, pp00_q} + {32'b0, pp01_q, 32'b0}
               + {8'b0, pp10_q, 32'b0} + {pp11_q, 64'b0};

  // products of 2^78 and above are capped and flag saturation
  assign cap = |m_q[103:78];
  assign r   = cap ? {1'b1, 62'b0} : {1'b0, m_q[77:16]};
  assign rnd = !cap && (|m_q[15:0]);
  assign r64 = {1'b0, r};
  assign c64 = {{16{pc_q.c_c[47]}}, pc_q.c_c};

  always_comb begin
    po_d     = pc_q;
    po_d.acc = neg_c_q ? (c64 + ~r64 + 64'(!rnd)) : (c64 + r64);
    po_d.c_c = pc_q.c_b;
    po_d.c_b = pc_q.c_a;
    po_d.c_a = '0;
    po_d.sat = pc_q.sat || cap;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
      vo_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pa_q    <= pkt_i;
    mag_q   <= pkt_i.acc[63] ? (~pkt_i.acc + 64'd1) : pkt_i.acc;
    neg_a_q <= pkt_i.acc[63] ^ pkt_i.x_neg;
    pb_q    <= pa_q;
    neg_b_q <= neg_a_q;
    pp00_q  <= mag_q[31:0] * pa_q.x_mag[31:0];
    pp01_q  <= mag_q[31:0] * pa_q.x_mag[39:32];
    pp10_q  <= mag_q[63:32] * pa_q.x_mag[31:0];
    pp11_q  <= mag_q[63:32] * pa_q.x_mag[39:32];
    pc_q    <= pb_q;
    neg_c_q <= neg_b_q;
    m_q     <= m_sum;
    po_q    <= po_d;
  end

  assign valid_o = vo_q;
  assign pkt_o   = po_q;

endmodule

@@ hw/rtl/bilinear_table_cubic_correction.sv @@
// Top level: bilinear coefficient table with cubic frequency correction.
//
//  channel  direction  handshake              payload
//  in       sink       in_valid_i/in_ready_o  operation .. frequency_offset
//  out      source     out_valid_o/out_ready_i baseband_frequency, saturated
//  cfg      sink       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One item per cycle sustained while the item queue has room; a query result
// passes through the item queue, 4 interpolation stages, 3 Horner steps of
// 4 stages each and the result queue. Writes give no result.
// The result queue holds 32 entries; queries leave the item queue only
// while a result slot is reserved for them, so output stalls back up there.
// No clearing after reset: the user must ensure table entries are read only once written; not enforced.
`include "assert_macros.svh"

module bilinear_table_cubic_correction #(
  parameter int unsigned AZIMUTH_BINS = 64,
  parameter int unsigned ORBIT_BINS   = 32,
  parameter int unsigned BEAMS        = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [23:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               operation_i,
  input  logic               beam_i,
  input  logic [4:0]         orbit_bin_i,
  input  logic [5:0]         azimuth_bin_i,
  input  logic [1:0]         coefficient_select_i,
  input  logic signed [31:0] coefficient_value_i,
  input  logic [15:0]        azimuth_turn_i,
  input  logic [15:0]        orbit_fraction_i,
  input  logic signed [23:0] frequency_offset_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] baseband_frequency_o,
  output logic               saturated_o
);
  import btcc_pkg::*;

  localparam int unsigned EW = $bits(entry_t);

  // configuration
  logic [13:0] steps_q;
  logic [23:0] recip_q, scale_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_q <= 14'd8192;
      recip_q <= 24'd65536;
      scale_q <= 24'd16384;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_STEPS: steps_q <= cfg_data_i[13:0];
        CFG_RECIP: recip_q <= cfg_data_i;
        CFG_SCALE: scale_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // front end and item queue
  logic   keep, q_full, q_valid, q_pop, q_push;
  entry_t front_entry, q_head;
  logic [EW-1:0] q_rdata;

  btcc_front #(
    .AZIMUTH_BINS(AZIMUTH_BINS),
    .BEAMS       (BEAMS),
    .ORBIT_BINS  (ORBIT_BINS)
  ) u_front (
    .operation_i         (operation_i),
    .beam_i              (beam_i),
    .orbit_bin_i         (orbit_bin_i),
    .azimuth_bin_i       (azimuth_bin_i),
    .coefficient_select_i(coefficient_select_i),
    .coefficient_value_i (coefficient_value_i),
    .azimuth_turn_i      (azimuth_turn_i),
    .orbit_fraction_i    (orbit_fraction_i),
    .frequency_offset_i  (frequency_offset_i),
    .steps_i             (steps_q),
    .scale_i             (scale_q),
    .keep_o              (keep),
    .entry_o             (front_entry)
  );

  assign in_ready_o = !q_full;
  assign q_push     = in_valid_i && in_ready_o && keep;

  btcc_fifo #(
    .W    (EW),
    .DEPTH(IN_DEPTH)
  ) u_item_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (front_entry),
    .full_o (q_full),
    .pop_i  (q_pop),
    .data_o (q_rdata),
    .valid_o(q_valid)
  );

  assign q_head = entry_t'(q_rdata);

  // result slots reserved by queries in flight
  logic [PEND_W-1:0] pending_q, pending_d;
  logic              pend_inc, out_take;

  assign q_pop    = q_valid && ((q_head.op == OP_WRITE)
                 || (pending_q < PEND_W'(OUT_DEPTH)));
  assign pend_inc = q_pop && (q_head.op == OP_EVAL);
  assign out_take = out_valid_o && out_ready_i;

  always_comb begin
    pending_d = pending_q;
    if (pend_inc && !out_take) begin
      pending_d = pending_q + 1'b1;
    end else if (out_take && !pend_inc) begin
      pending_d = pending_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  // back end
  logic        h_valid [4];
  horner_pkt_t h_pkt   [4];

  btcc_interp #(
    .AZIMUTH_BINS(AZIMUTH_BINS),
    .ORBIT_BINS  (ORBIT_BINS),
    .BEAMS       (BEAMS)
  ) u_interp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .steps_i(steps_q),
    .recip_i(recip_q),
    .pop_i  (q_pop),
    .head_i (q_head),
    .valid_o(h_valid[0]),
    .pkt_o  (h_pkt[0])
  );

  for (genvar gs = 0; gs < 3; gs++) begin : g_step
    btcc_horner u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(h_valid[gs]),
      .pkt_i  (h_pkt[gs]),
      .valid_o(h_valid[gs+1]),
      .pkt_o  (h_pkt[gs+1])
    );
  end

  // clip to 32 bits
  logic               ovf, res_sat, res_full, res_valid;
  logic signed [31:0] res_val;
  logic [32:0]        res_rdata;

  assign ovf     = (h_pkt[3].acc[63:31] != '0) && (h_pkt[3].acc[63:31] != '1);
  assign res_sat = h_pkt[3].sat || ovf;
  assign res_val = !ovf ? h_pkt[3].acc[31:0]
                 : (h_pkt[3].acc[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);

  btcc_fifo #(
    .W    (33),
    .DEPTH(OUT_DEPTH)
  ) u_result_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (h_valid[3]),
    .data_i ({res_sat, res_val}),
    .full_o (res_full),
    .pop_i  (out_take),
    .data_o (res_rdata),
    .valid_o(res_valid)
  );

  assign out_valid_o          = res_valid;
  assign baseband_frequency_o = res_rdata[31:0];
  assign saturated_o          = res_rdata[32];

  `BTCC_ASSERT(a_pending_bound, clk_i, rst_ni, pending_q <= PEND_W'(OUT_DEPTH), "slot count overrun")
  `BTCC_ASSERT_NEVER(a_result_overflow, clk_i, rst_ni, h_valid[3] && res_full, "result queue overflow")
  `BTCC_ASSERT(a_result_reserved, clk_i, rst_ni, !out_valid_o || (pending_q != '0), "unreserved result")
  `BTCC_ASSERT_NEVER(a_item_overflow, clk_i, rst_ni, q_push && q_full, "item queue overflow")

endmodule
